### rtl/core/gcb_pkg.sv
// Shared types and constants for the glyph coverage blend block.
`timescale 1ns / 1ps

package gcb_pkg;

	// Fixed limits of the placement and clipping logic.
	localparam int MAX_IMAGE_DIM = 4096;
	localparam int MAX_GLYPH_DIM = 1024;

	// Field widths.
	localparam int DIM_W    = 13;
	localparam int POS_W    = 14;
	localparam int GLYPH_W  = 10;
	localparam int CH_W     = 8;
	localparam int INDEX_W  = 24;
	localparam int PROD_W   = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Reciprocal of gray_max: ceil(2^RECIP_SHIFT / g), exact for 16-bit numerators.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int STEP_W      = 5;
	localparam int MUL_W       = PROD_W + RECIP_W;

	// Reset values of the configuration registers.
	localparam logic [DIM_W-1:0]      RST_IMAGE_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]      RST_IMAGE_HEIGHT = 13'd480;
	localparam logic [DIM_W-1:0]      RST_ORIGIN       = 13'd0;
	localparam logic [CFG_DATA_W-1:0] RST_COLOR_RGBA   = 32'd255;
	localparam logic [CH_W-1:0]       RST_GRAY_MAX     = 8'd255;
	localparam logic [RECIP_W-1:0]    RST_RECIP        = 25'd65794;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_ORIGIN_X     = 3'd2,
		REG_ORIGIN_Y     = 3'd3,
		REG_COLOR_RGBA   = 3'd4,
		REG_GRAY_MAX     = 3'd5
	} reg_index_t;

	// Decoded configuration as seen by the datapath.
	typedef struct packed {
		logic [DIM_W-1:0]        width;
		logic [DIM_W-1:0]        height;
		logic signed [DIM_W-1:0] origin_x;
		logic signed [DIM_W-1:0] origin_y;
		logic [CH_W-1:0]         red;
		logic [CH_W-1:0]         green;
		logic [CH_W-1:0]         blue;
		logic [CH_W-1:0]         alpha;
		logic [CH_W-1:0]         gray;
		logic [RECIP_W-1:0]      recip;
		logic                    busy;
	} cfg_t;

	// One classified sample in the queue between front and back.
	typedef struct packed {
		logic [CH_W-1:0]    strength;
		logic               in_image;
		logic [INDEX_W-1:0] pixel_index;
		logic [CH_W-1:0]    old_red;
		logic [CH_W-1:0]    old_green;
		logic [CH_W-1:0]    old_blue;
	} entry_t;

endpackage

### rtl/core/gcb_if.sv
// Channel interfaces of the glyph coverage blend block.
`timescale 1ns / 1ps

interface gcb_sample_if;
	logic                              valid;
	logic                              ready;
	logic [gcb_pkg::CH_W-1:0]          coverage;
	logic [gcb_pkg::GLYPH_W-1:0]       glyph_row;
	logic [gcb_pkg::GLYPH_W-1:0]       glyph_column;
	logic [gcb_pkg::CH_W-1:0]          old_red;
	logic [gcb_pkg::CH_W-1:0]          old_green;
	logic [gcb_pkg::CH_W-1:0]          old_blue;

	modport source (output valid, coverage, glyph_row, glyph_column, old_red, old_green,
		old_blue, input ready);
	modport sink (input valid, coverage, glyph_row, glyph_column, old_red, old_green,
		old_blue, output ready);
endinterface

interface gcb_result_if;
	logic                          valid;
	logic                          ready;
	logic [gcb_pkg::CH_W-1:0]      new_red;
	logic [gcb_pkg::CH_W-1:0]      new_green;
	logic [gcb_pkg::CH_W-1:0]      new_blue;
	logic [gcb_pkg::INDEX_W-1:0]   pixel_index;
	logic                          write_enable;

	modport source (output valid, new_red, new_green, new_blue, pixel_index, write_enable,
		input ready);
	modport sink (input valid, new_red, new_green, new_blue, pixel_index, write_enable,
		output ready);
endinterface

interface gcb_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [gcb_pkg::CFG_IDX_W-1:0]   index;
	logic [gcb_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/glyph_coverage_blend.sv
// Top level of the glyph coverage blend block.
//
//   channel  role     handshake      carries
//   sample   sink     valid/ready    coverage, glyph position, old pixel color
//   result   source   valid/ready    blended color, pixel index, write enable
//   cfg      sink     valid/ready    register index and write data
//
// One sample per cycle is taken and one result per cycle is given in steady state,
// when nothing stalls. A sample runs three front stages, the queue and three back
// stages from transfer in to result valid.
// After a gray_max write, samples are held off while the reciprocal sequencer
// produces one quotient bit per cycle; reset loads the reciprocal directly.
// A stalled result sink fills the queue before the sample channel drops ready.
`timescale 1ns / 1ps

module glyph_coverage_blend #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	gcb_sample_if.sink    sample,
	gcb_result_if.source  result,
	gcb_cfg_if.sink       cfg
);

	gcb_pkg::cfg_t   cfg_st;
	gcb_pkg::entry_t q_wdata, q_rdata;
	logic            q_push, q_pop, q_full, q_empty;

	// Configuration registers and reciprocal.
	gcb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_st (cfg_st)
	);

	// Placement, clipping and strength.
	gcb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample),
		.cfg_st  (cfg_st),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_wdata (q_wdata)
	);

	// Decoupling queue.
	gcb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Channel blending.
	gcb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_st  (cfg_st),
		.q_empty (q_empty),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);

`ifndef SYNTH
	// No sample is taken while the reciprocal is being recomputed.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |-> !cfg_st.busy)
		else $error("sample taken while reciprocal busy");

	// A gray_max write starts the reciprocal sequencer.
	a_gray_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index == gcb_pkg::REG_GRAY_MAX |=> cfg_st.busy)
		else $error("gray_max write did not start reciprocal");

	// The queue is never full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty together");

	// A clipped result carries a zero pixel index.
	a_clip_index: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.write_enable |-> result.pixel_index == '0)
		else $error("clipped result with nonzero index");
`endif

endmodule

### rtl/core/gcb_cfg.sv
// Configuration registers and the gray_max reciprocal sequencer.
`timescale 1ns / 1ps

module gcb_cfg (
	input  logic           clk,
	input  logic           arst_n,
	gcb_cfg_if.sink        cfg,
	output gcb_pkg::cfg_t  cfg_st
);

	logic [gcb_pkg::DIM_W-1:0]      width_q;
	logic [gcb_pkg::DIM_W-1:0]      height_q;
	logic [gcb_pkg::DIM_W-1:0]      origin_x_q;
	logic [gcb_pkg::DIM_W-1:0]      origin_y_q;
	logic [gcb_pkg::CFG_DATA_W-1:0] color_q;
	logic [gcb_pkg::CH_W-1:0]       gray_q;
	logic [gcb_pkg::RECIP_W-1:0]    recip_q;
	logic                           busy_q;
	logic [gcb_pkg::STEP_W-1:0]     step_q;
	logic [gcb_pkg::CH_W-1:0]       rem_q;
	logic [gcb_pkg::RECIP_W-1:0]    num_q;

	logic                           wr;
	logic [gcb_pkg::CH_W-1:0]       gray_eff;
	logic [gcb_pkg::CH_W-1:0]       gray_new;
	logic [gcb_pkg::CH_W:0]         trial;
	logic                           fits;
	logic [gcb_pkg::CH_W-1:0]       rem_n;
	logic [gcb_pkg::RECIP_W-1:0]    num_n;
	logic [gcb_pkg::DIM_W-1:0]      width_sat;
	logic [gcb_pkg::DIM_W-1:0]      height_sat;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid && cfg.ready;

	// A zero gray_max acts as one.
	assign gray_eff = (gray_q == '0) ? gray_q + 8'd1 : gray_q;
	assign gray_new = (cfg.data[gcb_pkg::CH_W-1:0] == '0) ? 8'd1 : cfg.data[gcb_pkg::CH_W-1:0];

	// One restoring division step: remainder stays below the divisor.
	assign trial = {rem_q, num_q[gcb_pkg::RECIP_W-1]};
	assign fits  = trial >= {1'b0, gray_eff};
	assign rem_n = fits ? gcb_pkg::CH_W'(trial - {1'b0, gray_eff})
		: trial[gcb_pkg::CH_W-1:0];
	assign num_n = {num_q[gcb_pkg::RECIP_W-2:0], fits};

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= gcb_pkg::RST_IMAGE_WIDTH;
			height_q   <= gcb_pkg::RST_IMAGE_HEIGHT;
			origin_x_q <= gcb_pkg::RST_ORIGIN;
			origin_y_q <= gcb_pkg::RST_ORIGIN;
			color_q    <= gcb_pkg::RST_COLOR_RGBA;
			gray_q     <= gcb_pkg::RST_GRAY_MAX;
		end else if (wr) begin
			unique case (gcb_pkg::reg_index_t'(cfg.index))
				gcb_pkg::REG_IMAGE_WIDTH:  width_q    <= cfg.data[gcb_pkg::DIM_W-1:0];
				gcb_pkg::REG_IMAGE_HEIGHT: height_q   <= cfg.data[gcb_pkg::DIM_W-1:0];
				gcb_pkg::REG_ORIGIN_X:     origin_x_q <= cfg.data[gcb_pkg::DIM_W-1:0];
				gcb_pkg::REG_ORIGIN_Y:     origin_y_q <= cfg.data[gcb_pkg::DIM_W-1:0];
				gcb_pkg::REG_COLOR_RGBA:   color_q    <= cfg.data;
				gcb_pkg::REG_GRAY_MAX:     gray_q     <= cfg.data[gcb_pkg::CH_W-1:0];
				default: ;
			endcase
		end
	end

	// Reciprocal sequencer: one quotient bit per cycle after a gray_max write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= gcb_pkg::RST_RECIP;
			busy_q  <= 1'b0;
			step_q  <= '0;
			rem_q   <= '0;
			num_q   <= '0;
		end else if (wr && cfg.index == gcb_pkg::REG_GRAY_MAX) begin
			busy_q <= 1'b1;
			step_q <= gcb_pkg::STEP_W'(gcb_pkg::RECIP_W);
			rem_q  <= '0;
			num_q  <= (gcb_pkg::RECIP_W'(1) << gcb_pkg::RECIP_SHIFT)
				+ gcb_pkg::RECIP_W'(gray_new) - gcb_pkg::RECIP_W'(1);
		end else if (busy_q) begin
			rem_q  <= rem_n;
			num_q  <= num_n;
			step_q <= step_q - 1'b1;
			if (step_q == gcb_pkg::STEP_W'(1)) begin
				recip_q <= num_n;
				busy_q  <= 1'b0;
			end
		end
	end

	// Image dimensions are limited to the largest supported size.
	assign width_sat  = (int'(width_q) > gcb_pkg::MAX_IMAGE_DIM)
		? gcb_pkg::DIM_W'(gcb_pkg::MAX_IMAGE_DIM) : width_q;
	assign height_sat = (int'(height_q) > gcb_pkg::MAX_IMAGE_DIM)
		? gcb_pkg::DIM_W'(gcb_pkg::MAX_IMAGE_DIM) : height_q;

	assign cfg_st.width    = width_sat;
	assign cfg_st.height   = height_sat;
	assign cfg_st.origin_x = origin_x_q;
	assign cfg_st.origin_y = origin_y_q;
	assign cfg_st.red      = color_q[31:24];
	assign cfg_st.green    = color_q[23:16];
	assign cfg_st.blue     = color_q[15:8];
	assign cfg_st.alpha    = color_q[7:0];
	assign cfg_st.gray     = gray_eff;
	assign cfg_st.recip    = recip_q;
	assign cfg_st.busy     = busy_q;

endmodule

### rtl/core/gcb_front.sv
// Front pipeline: places and clips samples, computes index and strength.
`timescale 1ns / 1ps

module gcb_front (
	input  logic            clk,
	input  logic            arst_n,
	gcb_sample_if.sink      sample,
	input  gcb_pkg::cfg_t   cfg_st,
	input  logic            q_full,
	output logic            q_push,
	output gcb_pkg::entry_t q_wdata
);

	logic                            v_s1, v_s2, v_s3;
	logic                            adv1, adv2, adv3;
	logic                            take;

	logic [gcb_pkg::POS_W-1:0]       x_c, y_c;
	logic                            inside_c;
	logic [gcb_pkg::CH_W-1:0]        cov_c;

	logic                            inside_s1;
	logic [gcb_pkg::DIM_W-1:0]       x_s1, y_s1;
	logic [gcb_pkg::CH_W-1:0]        cov_s1;
	logic [gcb_pkg::CH_W-1:0]        old_r_s1, old_g_s1, old_b_s1;

	logic                            inside_s2;
	logic [gcb_pkg::DIM_W-1:0]       x_s2;
	logic [2*gcb_pkg::DIM_W-1:0]     yw_s2;
	logic [gcb_pkg::PROD_W-1:0]      prod_s2;
	logic [gcb_pkg::CH_W-1:0]        old_r_s2, old_g_s2, old_b_s2;

	logic [2*gcb_pkg::DIM_W-1:0]     idx_c;
	logic [gcb_pkg::MUL_W-1:0]       smul_c;
	logic [gcb_pkg::CH_W-1:0]        sq_c;
	gcb_pkg::entry_t                 entry_s3;

	// Stage advance chain, held off by a full queue.
	assign adv3   = !v_s3 || !q_full;
	assign adv2   = !v_s2 || adv3;
	assign adv1   = !v_s1 || adv2;
	assign sample.ready = adv1 && !cfg_st.busy;
	assign take   = sample.valid && sample.ready;
	assign q_push = v_s3 && !q_full;
	assign q_wdata = entry_s3;

	// Placement and clipping.
	assign x_c = {cfg_st.origin_x[gcb_pkg::DIM_W-1], cfg_st.origin_x}
		+ gcb_pkg::POS_W'(sample.glyph_column);
	assign y_c = {cfg_st.origin_y[gcb_pkg::DIM_W-1], cfg_st.origin_y}
		+ gcb_pkg::POS_W'(sample.glyph_row);
	assign inside_c = (int'(sample.glyph_row) < gcb_pkg::MAX_GLYPH_DIM)
		&& (int'(sample.glyph_column) < gcb_pkg::MAX_GLYPH_DIM)
		&& !x_c[gcb_pkg::POS_W-1] && !y_c[gcb_pkg::POS_W-1]
		&& (x_c[gcb_pkg::DIM_W-1:0] < cfg_st.width)
		&& (y_c[gcb_pkg::DIM_W-1:0] < cfg_st.height);
	assign cov_c = (sample.coverage > cfg_st.gray) ? cfg_st.gray : sample.coverage;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= take;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: clipped position and saturated coverage.
	always_ff @(posedge clk) begin
		if (adv1) begin
			inside_s1 <= inside_c;
			x_s1      <= x_c[gcb_pkg::DIM_W-1:0];
			y_s1      <= y_c[gcb_pkg::DIM_W-1:0];
			cov_s1    <= cov_c;
			old_r_s1  <= sample.old_red;
			old_g_s1  <= sample.old_green;
			old_b_s1  <= sample.old_blue;
		end
	end

	// Stage 2: row offset and coverage times alpha.
	always_ff @(posedge clk) begin
		if (adv2) begin
			inside_s2 <= inside_s1;
			x_s2      <= x_s1;
			yw_s2     <= y_s1 * cfg_st.width;
			prod_s2   <= cov_s1 * cfg_st.alpha;
			old_r_s2  <= old_r_s1;
			old_g_s2  <= old_g_s1;
			old_b_s2  <= old_b_s1;
		end
	end

	// Stage 3: pixel index and strength by reciprocal multiply.
	assign idx_c  = yw_s2 + (2*gcb_pkg::DIM_W)'(x_s2);
	assign smul_c = gcb_pkg::MUL_W'(prod_s2) * gcb_pkg::MUL_W'(cfg_st.recip);
	assign sq_c   = smul_c[gcb_pkg::RECIP_SHIFT +: gcb_pkg::CH_W];

	always_ff @(posedge clk) begin
		if (adv3) begin
			entry_s3.in_image    <= inside_s2;
			entry_s3.pixel_index <= inside_s2 ? idx_c[gcb_pkg::INDEX_W-1:0] : '0;
			entry_s3.strength    <= (sq_c > cfg_st.gray) ? cfg_st.gray : sq_c;
			entry_s3.old_red     <= old_r_s2;
			entry_s3.old_green   <= old_g_s2;
			entry_s3.old_blue    <= old_b_s2;
		end
	end

endmodule

### rtl/core/gcb_queue.sv
// Short queue of classified samples between the front and back pipelines.
`timescale 1ns / 1ps

module gcb_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gcb_pkg::entry_t wdata,
	input  logic            pop,
	output gcb_pkg::entry_t rdata,
	output logic            full,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gcb_pkg::entry_t     mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

### rtl/core/gcb_back.sv
// Back pipeline: blends the three color channels and drives the result.
`timescale 1ns / 1ps

module gcb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  gcb_pkg::cfg_t   cfg_st,
	input  logic            q_empty,
	input  gcb_pkg::entry_t q_rdata,
	output logic            q_pop,
	gcb_result_if.source    result
);

	logic                             v_s1, v_s2, v_s3;
	logic                             adv1, adv2, adv3;

	logic [gcb_pkg::CH_W-1:0]         old_c [3];
	logic [gcb_pkg::CH_W-1:0]         col_c [3];
	logic [gcb_pkg::CH_W-1:0]         keep_c;

	logic [gcb_pkg::PROD_W-1:0]       p_old_s1 [3];
	logic [gcb_pkg::PROD_W-1:0]       p_col_s1 [3];
	logic [gcb_pkg::CH_W-1:0]         old_s1 [3];
	logic                             inside_s1;
	logic [gcb_pkg::INDEX_W-1:0]      idx_s1;

	logic [gcb_pkg::PROD_W-1:0]       sum_s2 [3];
	logic [gcb_pkg::CH_W-1:0]         old_s2 [3];
	logic                             inside_s2;
	logic [gcb_pkg::INDEX_W-1:0]      idx_s2;

	logic [gcb_pkg::MUL_W-1:0]        mul_c [3];
	logic [gcb_pkg::CH_W-1:0]         new_s3 [3];
	logic                             inside_s3;
	logic [gcb_pkg::INDEX_W-1:0]      idx_s3;

	// Stage advance chain, held off by the result sink.
	assign adv3  = !v_s3 || result.ready;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign q_pop = !q_empty && adv1;

	assign old_c[0] = q_rdata.old_red;
	assign old_c[1] = q_rdata.old_green;
	assign old_c[2] = q_rdata.old_blue;
	assign col_c[0] = cfg_st.red;
	assign col_c[1] = cfg_st.green;
	assign col_c[2] = cfg_st.blue;
	assign keep_c   = cfg_st.gray - q_rdata.strength;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= q_pop;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	// Stage 1: per-channel weighted products.
	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int c = 0; c < 3; c++) begin
				p_old_s1[c] <= old_c[c] * keep_c;
				p_col_s1[c] <= col_c[c] * q_rdata.strength;
				old_s1[c]   <= old_c[c];
			end
			inside_s1 <= q_rdata.in_image;
			idx_s1    <= q_rdata.pixel_index;
		end
	end

	// Stage 2: weighted sums, at most 255 times gray_max.
	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int c = 0; c < 3; c++) begin
				sum_s2[c] <= p_old_s1[c] + p_col_s1[c];
				old_s2[c] <= old_s1[c];
			end
			inside_s2 <= inside_s1;
			idx_s2    <= idx_s1;
		end
	end

	// Stage 3: divide by gray_max through its reciprocal, clipped samples keep old color.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			mul_c[c] = gcb_pkg::MUL_W'(sum_s2[c]) * gcb_pkg::MUL_W'(cfg_st.recip);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int c = 0; c < 3; c++) begin
				new_s3[c] <= inside_s2 ? mul_c[c][gcb_pkg::RECIP_SHIFT +: gcb_pkg::CH_W]
					: old_s2[c];
			end
			inside_s3 <= inside_s2;
			idx_s3    <= idx_s2;
		end
	end

	assign result.valid        = v_s3;
	assign result.new_red      = new_s3[0];
	assign result.new_green    = new_s3[1];
	assign result.new_blue     = new_s3[2];
	assign result.pixel_index  = idx_s3;
	assign result.write_enable = inside_s3;

endmodule
